### hw/rtl/gfp_column_normalize_weight_macros.svh
// Assertion macros shared by the column normalizer RTL.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef GFP_COLUMN_NORMALIZE_WEIGHT_MACROS_SVH
`define GFP_COLUMN_NORMALIZE_WEIGHT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GCNW_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GCNW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/gcnw_pkg.sv
// Package for the GF(p) column normalizer: widths, register indexes, queue types
// and the small mod-p reduction function. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package gcnw_pkg;

  localparam int MAX_ROWS    = 12;
  localparam int MAX_PRIME   = 31;
  localparam int VAL_W       = 5;
  localparam int LBL_W       = 8;
  localparam int ROW_W       = 4;
  localparam int SUM_W       = 60;
  localparam int PROD_W      = 2 * VAL_W;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 5;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CFG_IDX_W-1:0] REG_PRIME = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS  = 1'b1;

  // One classified row, passed from the front end to the back end.
  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic [LBL_W-1:0] label;
    logic             last;
  } q_item_t;

  // One result transaction.
  typedef struct packed {
    logic [VAL_W-1:0] norm_value;
    logic             column_done;
    logic [ROW_W-1:0] distinct_weight;
    logic [ROW_W-1:0] nonzero_count;
    logic [SUM_W-1:0] position_rank;
    logic [SUM_W-1:0] value_rank;
  } res_t;

  // Restoring reduction of a mod p. Valid when a < p * 2**VAL_W.
  function automatic logic [VAL_W-1:0] mod_reduce(input logic [PROD_W-1:0] a,
                                                  input logic [VAL_W-1:0]  p);
    logic [PROD_W-1:0] rem;
    logic [PROD_W-1:0] step;
    rem = a;
    for (int k = VAL_W - 1; k >= 0; k--) begin
      step = PROD_W'(p) << k;
      if (rem >= step) begin
        rem = rem - step;
      end
    end
    return rem[VAL_W-1:0];
  endfunction

endpackage

`default_nettype wire

### hw/rtl/gcnw_queue.sv
// Short queue of classified rows between the front end and the back end.
// Depends on gcnw_pkg for the entry type and depth.
`timescale 1ns / 1ps
`default_nettype none

module gcnw_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire gcnw_pkg::q_item_t push_item,
  input  wire logic             pop,
  output gcnw_pkg::q_item_t     head,
  output logic                  full,
  output logic                  empty
);
  import gcnw_pkg::*;

  q_item_t           slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

### hw/rtl/gcnw_front.sv
// Front end: accepts input transactions, reduces the element mod p and marks
// the last row of each column. Depends on gcnw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gcnw_front (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic [gcnw_pkg::VAL_W-1:0] prime,
  input  wire logic [gcnw_pkg::ROW_W-1:0] rows,
  input  wire logic                      item_valid,
  output logic                           item_stall,
  input  wire logic [gcnw_pkg::VAL_W-1:0] elem_value,
  input  wire logic [gcnw_pkg::LBL_W-1:0] factor_id,
  input  wire logic                      queue_full,
  output logic                           push,
  output gcnw_pkg::q_item_t              push_item
);
  import gcnw_pkg::*;

  logic [ROW_W-1:0] row_index;
  logic             last_row;

  assign last_row   = ({1'b0, row_index} + 1'b1) >= {1'b0, rows};
  assign item_stall = queue_full;
  assign push       = item_valid && !queue_full;

  always_comb begin
    push_item.value = mod_reduce({{(PROD_W - VAL_W){1'b0}}, elem_value}, prime);
    push_item.label = factor_id;
    push_item.last  = last_row;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_index <= '0;
    end else if (push) begin
      row_index <= last_row ? '0 : row_index + 1'b1;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/gcnw_back.sv
// Back end: inverse search, mod-p normalize, label set, rank accumulators and
// the output register. Depends on gcnw_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "gfp_column_normalize_weight_macros.svh"

module gcnw_back (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic [gcnw_pkg::VAL_W-1:0] prime,
  input  wire gcnw_pkg::q_item_t         head,
  input  wire logic                      queue_empty,
  output logic                           pop,
  output logic                           result_valid,
  input  wire logic                      result_stall,
  output gcnw_pkg::res_t                 result
);
  import gcnw_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_INV  = 5'b00010,
    S_MUL  = 5'b00100,
    S_RED  = 5'b01000,
    S_ACC  = 5'b10000
  } back_state_t;

  back_state_t         state;
  q_item_t             work;
  logic                leader_seen;
  logic [VAL_W-1:0]    column_inverse;
  logic [VAL_W-1:0]    search_m;
  logic [VAL_W-1:0]    search_r;
  logic [PROD_W-1:0]   product;
  logic [VAL_W-1:0]    norm;
  logic                label_hit;
  logic [LBL_W-1:0]    seen_labels [MAX_ROWS];
  logic [ROW_W-1:0]    seen_count;
  logic [ROW_W-1:0]    nonzero_total;
  logic [SUM_W-1:0]    position_sum;
  logic [SUM_W-1:0]    value_sum;
  logic [SUM_W-1:0]    row_power;

  logic [MAX_ROWS-1:0]     label_match;
  logic                    out_free;
  logic                    acc_fire;
  logic                    norm_nz;
  logic                    label_new;
  logic [ROW_W-1:0]        nonzero_next;
  logic [ROW_W-1:0]        seen_count_next;
  logic [SUM_W-1:0]        position_next;
  logic [SUM_W-1:0]        value_next;
  logic [SUM_W-1:0]        power_next;
  logic [SUM_W+VAL_W-1:0]  value_wide;
  logic [SUM_W+VAL_W-1:0]  power_wide;
  logic [VAL_W:0]          two_v;
  logic [VAL_W:0]          r_sum;
  logic                    search_over;
  logic                    head_leader;
  logic                    head_self_inverse;

  assign out_free = !result_valid || !result_stall;
  assign acc_fire = (state == S_ACC) && out_free;
  assign pop      = (state == S_IDLE) && !queue_empty;

  // Leader classification of the row at the head of the queue.
  assign head_leader       = !leader_seen && (head.value != '0);
  assign head_self_inverse = (head.value == VAL_W'(1)) || (head.value == prime - 1'b1);
  assign two_v             = {head.value, 1'b0};

  // Running residue r = v * m mod p for the inverse search.
  assign r_sum       = {1'b0, search_r} + {1'b0, work.value};
  assign search_over = ({1'b0, search_m} + (VAL_W + 1)'(2)) > {1'b0, prime};

  always_comb begin
    for (int i = 0; i < MAX_ROWS; i++) begin
      label_match[i] = (ROW_W'(i) < seen_count) && (seen_labels[i] == work.label);
    end
  end

  always_comb begin
    norm_nz         = (norm != '0);
    label_new       = norm_nz && !label_hit && (seen_count < ROW_W'(MAX_ROWS));
    nonzero_next    = norm_nz ? nonzero_total + 1'b1 : nonzero_total;
    seen_count_next = label_new ? seen_count + 1'b1 : seen_count;
    position_next   = norm_nz ? position_sum + row_power : position_sum;
    value_wide      = value_sum * prime;
    power_wide      = row_power * prime;
    value_next      = value_wide[SUM_W-1:0] + SUM_W'(norm);
    power_next      = power_wide[SUM_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      work <= head;
    end
    if (state == S_MUL) begin
      product <= column_inverse * work.value;
    end
    if (state == S_RED) begin
      norm      <= mod_reduce(product, prime);
      label_hit <= |label_match;
    end
    if (acc_fire && label_new) begin
      seen_labels[seen_count] <= work.label;
    end
    if (acc_fire) begin
      result.norm_value      <= norm;
      result.column_done     <= work.last;
      result.distinct_weight <= work.last ? seen_count_next : '0;
      result.nonzero_count   <= work.last ? nonzero_next : '0;
      result.position_rank   <= work.last ? position_next : '0;
      result.value_rank      <= work.last ? value_next : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      leader_seen    <= 1'b0;
      column_inverse <= '0;
      search_m       <= '0;
      search_r       <= '0;
      seen_count     <= '0;
      nonzero_total  <= '0;
      position_sum   <= '0;
      value_sum      <= '0;
      row_power      <= SUM_W'(1);
      result_valid   <= 1'b0;
    end else begin
      if (acc_fire) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (pop) begin
            if (head_leader && head_self_inverse) begin
              column_inverse <= head.value;
              leader_seen    <= 1'b1;
              state          <= S_MUL;
            end else if (head_leader) begin
              search_m <= VAL_W'(2);
              search_r <= (two_v >= {1'b0, prime}) ? VAL_W'(two_v - {1'b0, prime})
                                                   : two_v[VAL_W-1:0];
              state    <= S_INV;
            end else begin
              state <= S_MUL;
            end
          end
        end
        S_INV: begin
          if (search_over) begin
            column_inverse <= '0;
            leader_seen    <= 1'b1;
            state          <= S_MUL;
          end else if (search_r == VAL_W'(1)) begin
            column_inverse <= search_m;
            leader_seen    <= 1'b1;
            state          <= S_MUL;
          end else begin
            search_m <= search_m + 1'b1;
            search_r <= (r_sum >= {1'b0, prime}) ? VAL_W'(r_sum - {1'b0, prime})
                                                 : r_sum[VAL_W-1:0];
          end
        end
        S_MUL: begin
          state <= S_RED;
        end
        S_RED: begin
          state <= S_ACC;
        end
        S_ACC: begin
          if (out_free) begin
            state <= S_IDLE;
            if (work.last) begin
              leader_seen    <= 1'b0;
              column_inverse <= '0;
              seen_count     <= '0;
              nonzero_total  <= '0;
              position_sum   <= '0;
              value_sum      <= '0;
              row_power      <= SUM_W'(1);
            end else begin
              seen_count    <= seen_count_next;
              nonzero_total <= nonzero_next;
              position_sum  <= position_next;
              value_sum     <= value_next;
              row_power     <= power_next;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `GCNW_ASSERT_SAME(a_search_before_leader, state == S_INV, !leader_seen, "late search")
  `GCNW_ASSERT_SAME(a_distinct_le_nonzero, 1'b1, seen_count <= nonzero_total, "bad distinct")
  `GCNW_ASSERT_NEXT(a_acc_gives_result, acc_fire, result_valid, "row gave no result")
  `GCNW_ASSERT_NEXT(a_last_clears_column, acc_fire && work.last,
                    !leader_seen && nonzero_total == '0, "column not cleared")

endmodule

`default_nettype wire

### hw/rtl/gfp_column_normalize_weight.sv
// Top level of the GF(p) column normalizer: configuration registers and the
// front end, queue and back end. Depends on gcnw_pkg, gcnw_front, gcnw_queue, gcnw_back.
//
// Usage. Rows of a column arrive on the item channel (item_valid, item_stall,
// elem_value, factor_id); a transaction is taken at a rising edge with item_valid
// high and item_stall low. Each row yields one result transaction on the result
// channel (result_valid, result_stall and the result fields); the last row of a
// column carries column_done and the column summary, other rows carry zeros there.
// Configuration writes use cfg_valid/cfg_ready with cfg_index and cfg_data; index 0
// is the prime modulus, index 1 the row count. cfg_ready is always high, and writes
// are meant for idle periods between columns.
// Timing. An accepted row passes through the queue, the work register, the states S_MUL,
// S_RED and S_ACC and the output register; the first nonzero row of a column adds the
// inverse search, one candidate per cycle, unless its element is 1 or p-1. The back-end
// sequencer takes the next row from the queue only after S_ACC registers the last result.
// Stalls. A two-entry queue lets the front end keep accepting while the back end
// works or the result register waits; item_stall rises when the queue is full.
// A stalled result holds in the output register and the back end waits.
// Reset. rst is synchronous and active high; it loads p = 2 and 12 rows and clears
// the column state, the queue and the result valid flag.
`timescale 1ns / 1ps
`default_nettype none

module gfp_column_normalize_weight (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           item_valid,
  output logic                                item_stall,
  input  wire logic [gcnw_pkg::VAL_W-1:0]      elem_value,
  input  wire logic [gcnw_pkg::LBL_W-1:0]      factor_id,
  output logic                                result_valid,
  input  wire logic                           result_stall,
  output logic [gcnw_pkg::VAL_W-1:0]           norm_value,
  output logic                                column_done,
  output logic [gcnw_pkg::ROW_W-1:0]           distinct_weight,
  output logic [gcnw_pkg::ROW_W-1:0]           nonzero_count,
  output logic [gcnw_pkg::SUM_W-1:0]           position_rank,
  output logic [gcnw_pkg::SUM_W-1:0]           value_rank,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [gcnw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [gcnw_pkg::CFG_DATA_W-1:0] cfg_data
);
  import gcnw_pkg::*;

  logic [VAL_W-1:0] prime_modulus;
  logic [ROW_W-1:0] row_count;
  logic [VAL_W-1:0] eff_prime;
  logic [ROW_W-1:0] eff_rows;

  q_item_t push_item;
  q_item_t head;
  logic    push;
  logic    pop;
  logic    queue_full;
  logic    queue_empty;
  res_t    result;

  // The configuration port never pushes back.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      prime_modulus <= VAL_W'(2);
      row_count     <= ROW_W'(MAX_ROWS);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_PRIME: prime_modulus <= cfg_data[VAL_W-1:0];
        REG_ROWS:  row_count     <= cfg_data[ROW_W-1:0];
      endcase
    end
  end

  // A modulus below two behaves as two; the row count is clamped to 1..MAX_ROWS.
  // The 5-bit register cannot exceed the largest supported prime.
  assign eff_prime = (prime_modulus < VAL_W'(2)) ? VAL_W'(2) : prime_modulus;
  assign eff_rows  = (row_count == '0)               ? ROW_W'(1) :
                     (row_count > ROW_W'(MAX_ROWS)) ? ROW_W'(MAX_ROWS) : row_count;

  gcnw_front u_front (
    .clk        (clk),
    .rst        (rst),
    .prime      (eff_prime),
    .rows       (eff_rows),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .elem_value (elem_value),
    .factor_id  (factor_id),
    .queue_full (queue_full),
    .push       (push),
    .push_item  (push_item)
  );

  gcnw_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .full      (queue_full),
    .empty     (queue_empty)
  );

  gcnw_back u_back (
    .clk          (clk),
    .rst          (rst),
    .prime        (eff_prime),
    .head         (head),
    .queue_empty  (queue_empty),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  assign norm_value      = result.norm_value;
  assign column_done     = result.column_done;
  assign distinct_weight = result.distinct_weight;
  assign nonzero_count   = result.nonzero_count;
  assign position_rank   = result.position_rank;
  assign value_rank      = result.value_rank;

endmodule

`default_nettype wire
